// ===== sv/tpsc_pkg.sv =====
// Shared types, widths, codes and helpers for the triac phase-angle speed controller.
// No dependencies; every other file imports this package.
package tpsc_pkg;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned SPEED_W    = 15;
  localparam int unsigned KNOB_W     = 10;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned DELAY_W    = 16;
  localparam int unsigned DRIVE_W    = 16;
  localparam int unsigned MAXD_W     = 15;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned OPND_W     = 17;
  localparam int unsigned ACC_W      = 36;
  localparam int unsigned FRAC_W     = 8;
  localparam int unsigned DELTA_W    = ACC_W - FRAC_W;
  localparam int unsigned SUM_W      = 29;
  localparam int unsigned FCOUNT_W   = 32;
  localparam int unsigned TICK_W     = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned TICKS_PER_UPDATE_DEF = 5;

  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ZERO  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIRED = 2'd2;

  localparam logic [MODE_W-1:0] MODE_OFF = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RUN = 2'd1;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_DELAY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KNOB_DIVISOR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D       = 3'd5;

  localparam logic [MAXD_W-1:0] MAX_DELAY_RST = 15'd18000;

  localparam logic signed [DRIVE_W-1:0]  STALL_DRIVE = 16'sd9000;
  localparam logic signed [DRIVE_W-1:0]  STALL_ERROR = 16'sd350;
  localparam logic [FCOUNT_W-1:0]        STALL_FIRES = 32'd400;

  typedef struct packed {
    logic                     start;
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic signed [OPND_W-1:0] err;
    logic signed [OPND_W-1:0] err_sum;
    logic signed [OPND_W-1:0] err_diff;
  } mac_req_t;

  function automatic logic signed [DRIVE_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
    logic signed [DRIVE_W-1:0] r;
    if (v > SUM_W'(32'sd32767)) begin
      r = 16'sd32767;
    end else if (v < SUM_W'(-32'sd32768)) begin
      r = -16'sd32768;
    end else begin
      r = v[DRIVE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/tpsc_in_if.sv =====
// Input channel: command item with valid/ready handshake.
// Depends on tpsc_pkg for field widths.
interface tpsc_in_if;
  import tpsc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     cmd;
  logic [SPEED_W-1:0]   speed_reading;
  logic [KNOB_W-1:0]    knob_reading;
  logic [MODE_W-1:0]    run_mode;
  modport source (output valid, cmd, speed_reading, knob_reading, run_mode, input ready);
  modport sink   (input valid, cmd, speed_reading, knob_reading, run_mode, output ready);
endinterface

// ===== sv/tpsc_out_if.sv =====
// Output channel: one result item per command, valid/ready handshake.
// Depends on tpsc_pkg for field widths.
interface tpsc_out_if;
  import tpsc_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       fire;
  logic [DELAY_W-1:0]         fire_delay;
  logic signed [DRIVE_W-1:0]  drive_level;
  logic                       fault;
  modport source (output valid, fire, fire_delay, drive_level, fault, input ready);
  modport sink   (input valid, fire, fire_delay, drive_level, fault, output ready);
endinterface

// ===== sv/triac_phase_pid_speed_control.sv =====
// Triac phase-angle speed controller with a PID speed loop.
// Depends on tpsc_pkg, tpsc_in_if, tpsc_out_if, tpsc_div and tpsc_mac.
//
// Every accepted command yields one result transfer. Zero crossings, fire events,
// unused commands and ticks that do not complete an update go from IDLE to OUT,
// where they reach the output register once it is free. A tick that completes an
// update runs the PID: the knob divide in the bit-serial divider (DIV), then the
// three gain products in the shared serial multiply-accumulate unit (MUL), one gain
// bit sweep per gain. In run mode the result passes through DIV, MUL, UPD and OUT;
// in the other modes the multiply is skipped (DIV, UPD, OUT). OUT waits while the
// previous result still waits for its transfer. A new command is taken once the
// previous one has reached the output register, even while that result waits for
// its transfer.
module triac_phase_pid_speed_control #(
  parameter int unsigned TICKS_PER_UPDATE = tpsc_pkg::TICKS_PER_UPDATE_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tpsc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tpsc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  tpsc_in_if.sink                            in_if,
  tpsc_out_if.source                         out_if
);
  import tpsc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  localparam logic [TICK_W-1:0] TICK_TOP = TICK_W'(TICKS_PER_UPDATE);

  logic [MAXD_W-1:0]          max_delay_q;
  logic [SPEED_W-1:0]         target_speed_q;
  logic [KNOB_W-1:0]          knob_divisor_q;
  logic signed [GAIN_W-1:0]   gain_p_q;
  logic signed [GAIN_W-1:0]   gain_i_q;
  logic signed [GAIN_W-1:0]   gain_d_q;

  logic [2:0]                 state_q;
  logic [TICK_W-1:0]          tick_q;
  logic signed [DRIVE_W-1:0]  drive_q;
  logic signed [DRIVE_W-1:0]  err_sum_q;
  logic signed [DRIVE_W-1:0]  last_err_q;
  logic signed [DRIVE_W-1:0]  err_q;
  logic signed [OPND_W-1:0]   err_diff_q;
  logic [FCOUNT_W-1:0]        fire_count_q;
  logic                       fault_q;
  logic [MODE_W-1:0]          mode_q;
  logic [SPEED_W-1:0]         speed_q;
  logic                       fire_q;
  logic [DELAY_W-1:0]         delay_q;

  logic                       out_valid_q;
  logic                       out_fire_q;
  logic [DELAY_W-1:0]         out_delay_q;
  logic signed [DRIVE_W-1:0]  out_drive_q;
  logic                       out_fault_q;

  logic                       accept;
  logic                       out_free;
  logic [TICK_W-1:0]          tick_next;
  logic                       div_start;
  logic                       div_done;
  logic [KNOB_W-1:0]          quotient;
  logic                       mac_done;
  logic signed [ACC_W-1:0]    acc;
  mac_req_t                   mac_req;

  logic signed [DRIVE_W-1:0]  max_ext;
  logic signed [DRIVE_W-1:0]  drive_clamp;
  logic signed [OPND_W-1:0]   err_raw;
  logic signed [DRIVE_W-1:0]  err_new;
  logic signed [DRIVE_W-1:0]  err_sum_new;
  logic signed [OPND_W-1:0]   err_diff_new;
  logic signed [DELTA_W-1:0]  delta;
  logic signed [DRIVE_W-1:0]  drive_new;
  logic                       stall;

  assign accept       = in_if.valid && in_if.ready;
  assign in_if.ready  = (state_q == S_IDLE);
  assign out_free     = !out_valid_q || out_if.ready;
  assign tick_next    = tick_q + 1'b1;
  assign div_start    = accept && !fault_q && (in_if.cmd == CMD_TICK) && (tick_next >= TICK_TOP);

  always_comb begin
    max_ext      = $signed({1'b0, max_delay_q});
    drive_clamp  = (drive_q > max_ext) ? max_ext : drive_q;
    err_raw      = $signed({2'b00, target_speed_q}) + $signed({7'b0, quotient})
                 - $signed({2'b00, speed_q});
    err_new      = sat16(SUM_W'(err_raw));
    err_sum_new  = sat16(SUM_W'(err_sum_q) + SUM_W'(err_new));
    err_diff_new = OPND_W'(err_new) - OPND_W'(last_err_q);
    delta        = acc[ACC_W-1:FRAC_W];
    if (acc[ACC_W-1] && (acc[FRAC_W-1:0] != '0)) begin
      delta = delta + DELTA_W'(1);
    end
    drive_new    = sat16(SUM_W'(drive_q) + SUM_W'(delta));
    stall        = (drive_q > STALL_DRIVE) && (err_q > STALL_ERROR)
                && (fire_count_q > STALL_FIRES);
  end

  always_comb begin
    mac_req          = '0;
    mac_req.start    = (state_q == S_DIV) && div_done && (mode_q == MODE_RUN);
    mac_req.gain_p   = gain_p_q;
    mac_req.gain_i   = gain_i_q;
    mac_req.gain_d   = gain_d_q;
    mac_req.err      = OPND_W'(err_new);
    mac_req.err_sum  = OPND_W'(err_sum_q);
    mac_req.err_diff = err_diff_q;
  end

  tpsc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (in_if.knob_reading),
    .divisor_i  (knob_divisor_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  tpsc_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .done_o (mac_done),
    .acc_o  (acc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_delay_q    <= MAX_DELAY_RST;
      target_speed_q <= '0;
      knob_divisor_q <= KNOB_W'(1);
      gain_p_q       <= '0;
      gain_i_q       <= '0;
      gain_d_q       <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAX_DELAY:    max_delay_q    <= cfg_data_i[MAXD_W-1:0];
        REG_TARGET_SPEED: target_speed_q <= cfg_data_i[SPEED_W-1:0];
        REG_KNOB_DIVISOR: knob_divisor_q <= cfg_data_i[KNOB_W-1:0];
        REG_GAIN_P:       gain_p_q       <= $signed(cfg_data_i[GAIN_W-1:0]);
        REG_GAIN_I:       gain_i_q       <= $signed(cfg_data_i[GAIN_W-1:0]);
        REG_GAIN_D:       gain_d_q       <= $signed(cfg_data_i[GAIN_W-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      tick_q       <= '0;
      drive_q      <= '0;
      err_sum_q    <= '0;
      last_err_q   <= '0;
      fire_count_q <= '0;
      fault_q      <= 1'b0;
      fire_q       <= 1'b0;
      delay_q      <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            fire_q  <= 1'b0;
            delay_q <= '0;
            state_q <= S_OUT;
            if (!fault_q) begin
              case (in_if.cmd)
                CMD_TICK: begin
                  if (tick_next >= TICK_TOP) begin
                    tick_q  <= '0;
                    state_q <= S_DIV;
                  end else begin
                    tick_q <= tick_next;
                  end
                end
                CMD_ZERO: begin
                  drive_q <= drive_clamp;
                  if (drive_clamp > 16'sd1) begin
                    fire_q  <= 1'b1;
                    delay_q <= DELAY_W'(max_ext - drive_clamp + 16'sd1);
                  end
                end
                CMD_FIRED: begin
                  if (in_if.run_mode == MODE_RUN) begin
                    fire_count_q <= fire_count_q + 1'b1;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            err_sum_q <= err_sum_new;
            if (mode_q == MODE_RUN) begin
              state_q <= S_MUL;
            end else begin
              if (mode_q == MODE_OFF) begin
                err_sum_q <= '0;
                drive_q   <= '0;
              end
              state_q <= S_UPD;
            end
          end
        end
        S_MUL: begin
          if (mac_done) begin
            drive_q <= drive_new;
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          if (stall) begin
            drive_q <= '0;
            fault_q <= 1'b1;
          end else begin
            last_err_q <= err_q;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= in_if.run_mode;
      speed_q <= in_if.speed_reading;
    end
    if ((state_q == S_DIV) && div_done) begin
      err_q      <= err_new;
      err_diff_q <= err_diff_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == S_OUT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_OUT) && out_free) begin
      out_fire_q  <= fire_q;
      out_delay_q <= delay_q;
      out_drive_q <= drive_q;
      out_fault_q <= fault_q;
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.fire        = out_fire_q;
  assign out_if.fire_delay  = out_delay_q;
  assign out_if.drive_level = out_drive_q;
  assign out_if.fault       = out_fault_q;

endmodule

// ===== sv/tpsc_div.sv =====
// Bit-serial restoring divider for the knob reading, one quotient bit per cycle.
// Depends on tpsc_pkg.
module tpsc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [tpsc_pkg::KNOB_W-1:0]   dividend_i,
  input  logic [tpsc_pkg::KNOB_W-1:0]   divisor_i,
  output logic                          done_o,
  output logic [tpsc_pkg::KNOB_W-1:0]   quotient_o
);
  import tpsc_pkg::*;

  localparam int unsigned CNT_W = $clog2(KNOB_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(KNOB_W - 1);

  logic                busy_q;
  logic                done_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [KNOB_W-1:0]   rem_q;
  logic [KNOB_W-1:0]   quo_q;
  logic [KNOB_W-1:0]   div_q;
  logic [KNOB_W:0]     trial;
  logic                qbit;
  logic [KNOB_W:0]     rem_d;

  always_comb begin
    trial = {rem_q, quo_q[KNOB_W-1]};
    qbit  = trial >= {1'b0, div_q};
    rem_d = qbit ? trial - {1'b0, div_q} : trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= (divisor_i == '0) ? KNOB_W'(1) : divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d[KNOB_W-1:0];
      quo_q <= {quo_q[KNOB_W-2:0], qbit};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== sv/tpsc_mac.sv =====
// Serial shift-add multiply-accumulate of the three PID terms, one gain bit per cycle.
// Depends on tpsc_pkg (mac_req_t, widths).
module tpsc_mac (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tpsc_pkg::mac_req_t                 req_i,
  output logic                               done_o,
  output logic signed [tpsc_pkg::ACC_W-1:0]  acc_o
);
  import tpsc_pkg::*;

  localparam int unsigned CNT_W = $clog2(GAIN_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GAIN_W - 1);
  localparam logic [1:0] SEL_P = 2'd0;
  localparam logic [1:0] SEL_I = 2'd1;
  localparam logic [1:0] SEL_D = 2'd2;

  logic                     busy_q;
  logic                     done_q;
  logic [1:0]               sel_q;
  logic [CNT_W-1:0]         cnt_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  mcand_q;
  logic [GAIN_W-1:0]        mplier_q;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  acc_d;
  logic signed [ACC_W-1:0]  next_mcand;
  logic [GAIN_W-1:0]        next_mplier;

  always_comb begin
    term  = mplier_q[0] ? mcand_q : '0;
    acc_d = (cnt_q == CNT_LAST) ? acc_q - term : acc_q + term;
    case (sel_q)
      SEL_P: begin
        next_mcand  = ACC_W'(req_i.err_sum);
        next_mplier = req_i.gain_i;
      end
      SEL_I: begin
        next_mcand  = ACC_W'(req_i.err_diff);
        next_mplier = req_i.gain_d;
      end
      default: begin
        next_mcand  = ACC_W'(req_i.err);
        next_mplier = req_i.gain_p;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      sel_q  <= SEL_P;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        sel_q  <= SEL_P;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          if (sel_q == SEL_D) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end else begin
            sel_q <= sel_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q    <= '0;
      mcand_q  <= ACC_W'(req_i.err);
      mplier_q <= req_i.gain_p;
    end else if (busy_q) begin
      acc_q <= acc_d;
      if (cnt_q == CNT_LAST) begin
        mcand_q  <= next_mcand;
        mplier_q <= next_mplier;
      end else begin
        mcand_q  <= mcand_q <<< 1;
        mplier_q <= mplier_q >> 1;
      end
    end
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule
